// File: design/lbni_pkg.sv
// Shared types, constants and codes for the lattice block neighbour indexer.
`default_nettype none

package lbni_pkg;

    localparam int MAX_BLOCKS_DEFAULT = 16;

    localparam int COORD_W    = 4;
    localparam int CFG_DIM_W  = 5;
    localparam int RANK_W     = 16;
    localparam int NIDX_W     = 17;
    localparam int CNT_W      = 13;
    localparam int FACES      = 8;
    localparam int FACE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_DIM0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_DIM1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_DIM2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_DIM3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUT_FACE_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PARITY  = 3'd5;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] coord0;
        logic [COORD_W-1:0] coord1;
        logic [COORD_W-1:0] coord2;
        logic [COORD_W-1:0] coord3;
    } in_word_t;

    typedef struct packed {
        logic [RANK_W-1:0] block_index;
        logic [FACE_W-1:0] direction;
        logic [NIDX_W-1:0] neighbour_index;
        logic              on_boundary;
        logic [RANK_W-1:0] far_partner_index;
        logic              build_done;
        logic              last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP1,
        ST_PREP2,
        ST_PREP3,
        ST_REDUCE,
        ST_BUILD,
        ST_BUILD_DONE,
        ST_OWN,
        ST_FACE,
        ST_LAST
    } state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic prep;
        logic reduce;
        logic build_step;
        logic build_emit;
        logic own_read;
        logic face_issue;
        logic face_emit;
    } cmd_t;

    typedef struct packed {
        logic reduce_done;
        logic build_last;
        logic face_first;
        logic face_last;
    } status_t;

endpackage

`default_nettype wire

// File: design/lbni_ctrl.sv
// Sequencing state machine for the neighbour indexer.
`default_nettype none

module lbni_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              operation,
    input  wire lbni_pkg::status_t status,
    output logic                   busy,
    output lbni_pkg::cmd_t         cmd
);

    lbni_pkg::state_t state_reg, state_next;
    logic             op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbni_pkg::ST_IDLE;
            op_reg    <= lbni_pkg::OP_BUILD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        op_next = op_reg;
        if (state_reg == lbni_pkg::ST_IDLE && start)
            op_next = operation;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbni_pkg::ST_IDLE:
                if (start) state_next = lbni_pkg::ST_PREP1;
            lbni_pkg::ST_PREP1:
                state_next = lbni_pkg::ST_PREP2;
            lbni_pkg::ST_PREP2:
                state_next = lbni_pkg::ST_PREP3;
            lbni_pkg::ST_PREP3:
                state_next = (op_reg == lbni_pkg::OP_BUILD) ? lbni_pkg::ST_BUILD
                                                            : lbni_pkg::ST_REDUCE;
            lbni_pkg::ST_REDUCE:
                if (status.reduce_done) state_next = lbni_pkg::ST_OWN;
            lbni_pkg::ST_BUILD:
                if (status.build_last) state_next = lbni_pkg::ST_BUILD_DONE;
            lbni_pkg::ST_BUILD_DONE:
                state_next = lbni_pkg::ST_IDLE;
            lbni_pkg::ST_OWN:
                state_next = lbni_pkg::ST_FACE;
            lbni_pkg::ST_FACE:
                if (status.face_last) state_next = lbni_pkg::ST_LAST;
            lbni_pkg::ST_LAST:
                state_next = lbni_pkg::ST_IDLE;
            default:
                state_next = lbni_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.load       = (state_reg == lbni_pkg::ST_IDLE) && start;
        cmd.mul1       = (state_reg == lbni_pkg::ST_PREP1);
        cmd.mul2       = (state_reg == lbni_pkg::ST_PREP2);
        cmd.prep       = (state_reg == lbni_pkg::ST_PREP3);
        cmd.reduce     = (state_reg == lbni_pkg::ST_REDUCE);
        cmd.build_step = (state_reg == lbni_pkg::ST_BUILD);
        cmd.build_emit = (state_reg == lbni_pkg::ST_BUILD_DONE);
        cmd.own_read   = (state_reg == lbni_pkg::ST_OWN);
        cmd.face_issue = (state_reg == lbni_pkg::ST_FACE);
        // face k's rank arrives in the cycle after its read
        cmd.face_emit  = (state_reg == lbni_pkg::ST_LAST) ||
                         ((state_reg == lbni_pkg::ST_FACE) && !status.face_first);
        busy           = (state_reg != lbni_pkg::ST_IDLE);
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

endmodule

`default_nettype wire

// File: design/lbni_dp.sv
// Datapath: configuration, size products, boundary offsets, rank memory, result register.
`default_nettype none

module lbni_dp #(
    parameter int MAX_BLOCKS_PER_DIM = lbni_pkg::MAX_BLOCKS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lbni_pkg::cmd_t                      cmd,
    output lbni_pkg::status_t                        status,
    input  wire lbni_pkg::in_word_t                  request,
    input  wire logic                                cfg_write,
    input  wire logic [lbni_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lbni_pkg::CFG_DATA_W-1:0]     cfg_data,
    output lbni_pkg::out_word_t                      result,
    output logic                                     result_valid
);

    localparam int CW    = $clog2(MAX_BLOCKS_PER_DIM);
    localparam int DW    = $clog2(MAX_BLOCKS_PER_DIM + 1);
    localparam int CRW   = (CW > lbni_pkg::COORD_W) ? CW : lbni_pkg::COORD_W;
    localparam int DEPTH = MAX_BLOCKS_PER_DIM ** 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int P2W   = 2 * DW;
    localparam int PW    = 3 * DW;
    localparam int NBW   = 4 * DW;
    localparam int NW    = lbni_pkg::NIDX_W;
    localparam int RW    = lbni_pkg::RANK_W;

    // configuration
    logic [lbni_pkg::CFG_DIM_W-1:0] dim_reg [4];
    logic [3:0]                     mask_reg;
    logic                           fp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int mu = 0; mu < 4; mu++)
                dim_reg[mu] <= lbni_pkg::CFG_DIM_W'(4);
            mask_reg <= '0;
            fp_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            priority case (cfg_index)
                lbni_pkg::REG_BLOCKS_DIM0:   dim_reg[0] <= cfg_data;
                lbni_pkg::REG_BLOCKS_DIM1:   dim_reg[1] <= cfg_data;
                lbni_pkg::REG_BLOCKS_DIM2:   dim_reg[2] <= cfg_data;
                lbni_pkg::REG_BLOCKS_DIM3:   dim_reg[3] <= cfg_data;
                lbni_pkg::REG_CUT_FACE_MASK: mask_reg   <= cfg_data[3:0];
                lbni_pkg::REG_FIRST_PARITY:  fp_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped sizes and their last coordinate
    logic [DW-1:0]  eff_d [4];
    logic [CRW-1:0] dm1   [4];

    always_comb
    begin
        for (int mu = 0; mu < 4; mu++)
        begin
            if (dim_reg[mu] == '0)
                eff_d[mu] = DW'(1);
            else if (int'(dim_reg[mu]) > MAX_BLOCKS_PER_DIM)
                eff_d[mu] = DW'(MAX_BLOCKS_PER_DIM);
            else
                eff_d[mu] = DW'(dim_reg[mu]);
            dm1[mu] = CRW'(eff_d[mu] - DW'(1));
        end
    end

    // size products
    logic [P2W-1:0] p01_reg, p23_reg;
    logic [NBW-1:0] nb_reg;
    logic [PW-1:0]  prod_reg [4];

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            p01_reg <= P2W'(eff_d[0]) * P2W'(eff_d[1]);
            p23_reg <= P2W'(eff_d[2]) * P2W'(eff_d[3]);
        end
        if (cmd.mul2)
        begin
            nb_reg      <= NBW'(p01_reg) * NBW'(p23_reg);
            prod_reg[0] <= PW'(eff_d[1]) * PW'(p23_reg);
            prod_reg[1] <= PW'(eff_d[0]) * PW'(p23_reg);
            prod_reg[2] <= PW'(p01_reg) * PW'(eff_d[3]);
            prod_reg[3] <= PW'(p01_reg) * PW'(eff_d[2]);
        end
    end

    // boundary counts per face and parity group
    logic [NW-1:0] ne_c [lbni_pkg::FACES];
    logic [NW-1:0] no_c [lbni_pkg::FACES];
    logic [NW-1:0] total_e_c;
    logic [PW:0]   nbb_w, half_w, rest_w;

    always_comb
    begin
        total_e_c = '0;
        for (int mu = 0; mu < 4; mu++)
        begin
            nbb_w  = mask_reg[mu] ? {1'b0, prod_reg[mu]} : '0;
            half_w = (nbb_w + (PW + 1)'(1)) >> 1;
            rest_w = nbb_w - half_w;
            if (fp_reg)
            begin
                ne_c[2*mu] = NW'(half_w);
                no_c[2*mu] = NW'(rest_w);
            end
            else
            begin
                ne_c[2*mu] = NW'(rest_w);
                no_c[2*mu] = NW'(half_w);
            end
            // odd extent keeps the parity across the lattice, even flips it
            if (eff_d[mu][0])
            begin
                ne_c[2*mu+1] = ne_c[2*mu];
                no_c[2*mu+1] = no_c[2*mu];
            end
            else
            begin
                ne_c[2*mu+1] = no_c[2*mu];
                no_c[2*mu+1] = ne_c[2*mu];
            end
        end
        for (int f = 0; f < lbni_pkg::FACES; f++)
            total_e_c = total_e_c + ne_c[f];
    end

    logic [NW-1:0] ne_reg [lbni_pkg::FACES];
    logic [NW-1:0] no_reg [lbni_pkg::FACES];
    logic [NW-1:0] total_e_reg;
    logic [NW-1:0] acc_e_reg, acc_o_reg;

    // coordinates, odometer, face counter
    logic [CRW-1:0]                c_reg  [4];
    logic [CRW-1:0]                bc_reg [4];
    logic [CRW-1:0]                bc_next [4];
    logic [3:0]                    bc_at_max;
    logic                          carry;
    logic [RW-1:0]                 r0_reg, r1_reg;
    logic [lbni_pkg::FACE_W-1:0]   fi_reg;
    logic [lbni_pkg::FACE_W-1:0]   ef;
    logic [RW-1:0]                 own_reg;
    logic                          tab_valid_reg;
    logic [lbni_pkg::CNT_W-1:0]    cnt_reg [16];

    always_comb
    begin
        carry = 1'b1;
        for (int mu = 3; mu >= 0; mu--)
        begin
            bc_at_max[mu] = (bc_reg[mu] == dm1[mu]);
            if (carry)
                bc_next[mu] = bc_at_max[mu] ? '0 : bc_reg[mu] + CRW'(1);
            else
                bc_next[mu] = bc_reg[mu];
            carry = carry && bc_at_max[mu];
        end
    end

    logic parity;
    assign parity = bc_reg[0][0] ^ bc_reg[1][0] ^ bc_reg[2][0] ^ bc_reg[3][0];

    logic reduce_done;
    always_comb
    begin
        reduce_done = 1'b1;
        for (int mu = 0; mu < 4; mu++)
            if (int'(c_reg[mu]) >= int'(eff_d[mu]))
                reduce_done = 1'b0;
    end

    // lexicographic strides and the span of a full wrap along each direction
    logic [AW-1:0] stride [4];
    logic [AW-1:0] wrap_d [4];
    logic [AW-1:0] lex_c;
    logic [AW-1:0] lex_reg;
    logic [AW-1:0] wr_cnt_reg;

    always_comb
    begin
        stride[0] = AW'(prod_reg[0]);
        stride[1] = AW'(p23_reg);
        stride[2] = AW'(eff_d[3]);
        stride[3] = AW'(1);
        wrap_d[0] = AW'(nb_reg - NBW'(prod_reg[0]));
        wrap_d[1] = AW'(prod_reg[0] - PW'(p23_reg));
        wrap_d[2] = AW'(p23_reg - P2W'(eff_d[3]));
        wrap_d[3] = AW'(eff_d[3] - DW'(1));
        lex_c     = AW'(c_reg[0]) * stride[0] + AW'(c_reg[1]) * stride[1] +
                    AW'(c_reg[2]) * stride[2] + AW'(c_reg[3]);
    end

    // periodic neighbour of the face being read; on a cut face it is the far partner
    logic [AW-1:0] own_addr, nbr_addr, wr_addr, rd_addr;
    logic [1:0]    fm;
    assign fm = fi_reg[2:1];

    always_comb
    begin
        if (fi_reg[0])
            nbr_addr = (c_reg[fm] == dm1[fm]) ? lex_reg - wrap_d[fm] : lex_reg + stride[fm];
        else
            nbr_addr = (c_reg[fm] == '0) ? lex_reg + wrap_d[fm] : lex_reg - stride[fm];
    end

    assign own_addr = lex_reg;
    assign wr_addr  = wr_cnt_reg;
    assign rd_addr  = cmd.own_read ? own_addr : nbr_addr;

    // rank table
    logic [RW-1:0] mem [DEPTH];
    logic [RW-1:0] rdata_reg;
    logic [RW-1:0] wdata;
    assign wdata = (parity == fp_reg) ? r0_reg : r1_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.build_step)
            mem[wr_addr] <= wdata;
        if (cmd.own_read || cmd.face_issue)
            rdata_reg <= mem[rd_addr];
    end

    // face being emitted
    logic          bnd, edge_hit, firstgrp;
    logic [3:0]    ci;
    logic [NW-1:0] off;
    assign ef       = fi_reg - lbni_pkg::FACE_W'(1);
    assign edge_hit = ef[0] ? (c_reg[ef[2:1]] == dm1[ef[2:1]]) : (c_reg[ef[2:1]] == '0);
    assign bnd      = mask_reg[ef[2:1]] && edge_hit;
    assign firstgrp = int'(own_reg) < int'(nb_reg >> 1);
    assign ci       = {!firstgrp, ef};
    assign off      = firstgrp ? total_e_reg + acc_o_reg : acc_e_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_reg[0] <= CRW'(request.coord0);
            c_reg[1] <= CRW'(request.coord1);
            c_reg[2] <= CRW'(request.coord2);
            c_reg[3] <= CRW'(request.coord3);
        end
        else if (cmd.reduce)
        begin
            for (int mu = 0; mu < 4; mu++)
                if (int'(c_reg[mu]) >= int'(eff_d[mu]))
                    c_reg[mu] <= c_reg[mu] - CRW'(eff_d[mu]);
        end
        // the last reduce cycle sees the reduced coordinates
        if (cmd.reduce)
            lex_reg <= lex_c;
        if (cmd.prep)
        begin
            for (int f = 0; f < lbni_pkg::FACES; f++)
            begin
                ne_reg[f] <= ne_c[f];
                no_reg[f] <= no_c[f];
            end
            total_e_reg <= total_e_c;
            acc_e_reg   <= '0;
            acc_o_reg   <= '0;
            for (int mu = 0; mu < 4; mu++)
                bc_reg[mu] <= '0;
            wr_cnt_reg <= '0;
            r0_reg <= '0;
            r1_reg <= RW'(nb_reg >> 1);
        end
        if (cmd.build_step)
        begin
            for (int mu = 0; mu < 4; mu++)
                bc_reg[mu] <= bc_next[mu];
            wr_cnt_reg <= wr_cnt_reg + AW'(1);
            if (parity == fp_reg)
                r0_reg <= r0_reg + RW'(1);
            else
                r1_reg <= r1_reg + RW'(1);
        end
        if (cmd.face_issue && fi_reg == '0)
            own_reg <= rdata_reg;
        if (cmd.face_emit)
        begin
            acc_e_reg <= acc_e_reg + ne_reg[ef];
            acc_o_reg <= acc_o_reg + no_reg[ef];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fi_reg        <= '0;
            tab_valid_reg <= 1'b0;
            for (int i = 0; i < 16; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            if (cmd.prep)
                fi_reg <= '0;
            else if (cmd.face_issue)
                fi_reg <= fi_reg + lbni_pkg::FACE_W'(1);
            if (cmd.build_emit)
            begin
                tab_valid_reg <= 1'b1;
                for (int i = 0; i < 16; i++)
                    cnt_reg[i] <= '0;
            end
            else if (cmd.face_emit && tab_valid_reg && bnd)
                cnt_reg[ci] <= cnt_reg[ci] + lbni_pkg::CNT_W'(1);
        end
    end

    // result word
    lbni_pkg::out_word_t result_reg, result_next;
    logic                valid_reg;

    always_comb
    begin
        result_next = '0;
        if (cmd.build_emit)
        begin
            result_next.build_done = 1'b1;
            result_next.last       = 1'b1;
        end
        else
        begin
            result_next.direction = ef;
            result_next.last      = (ef == lbni_pkg::FACE_W'(lbni_pkg::FACES - 1));
            if (tab_valid_reg)
            begin
                result_next.block_index = own_reg;
                if (bnd)
                begin
                    result_next.on_boundary       = 1'b1;
                    result_next.neighbour_index   = NW'(nb_reg) + off + NW'(cnt_reg[ci]);
                    result_next.far_partner_index = rdata_reg;
                end
                else
                    result_next.neighbour_index = NW'(rdata_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.build_emit || cmd.face_emit)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.build_emit || cmd.face_emit;
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

    always_comb
    begin
        status             = '0;
        status.reduce_done = reduce_done;
        status.build_last  = &bc_at_max;
        status.face_first  = (fi_reg == '0);
        status.face_last   = (fi_reg == lbni_pkg::FACE_W'(lbni_pkg::FACES - 1));
    end

    a_build_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && result_reg.build_done) |-> result_reg.last)
        else $error("build word not marked last");

    a_face_order: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_reg.last) |=>
            (valid_reg && result_reg.direction ==
             $past(result_reg.direction) + lbni_pkg::FACE_W'(1)))
        else $error("face words not consecutive");

    a_interior_partner: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_reg.on_boundary) |-> (result_reg.far_partner_index == '0))
        else $error("partner set on interior face");

endmodule

`default_nettype wire

// File: design/lattice_block_neighbour_indexer.sv
// Top level of the 4D block lattice neighbour indexer.
// Usage:
//   Command channel: a word (request) is taken when start is high and busy is low.
//   operation = build fills the even/odd rank table and clears the boundary
//   counters; one word with build_done and last follows.
//   operation = query gives eight words, faces -0,+0,..,-3,+3, the last one marked.
//   Results appear on result for one cycle with result_valid high; the receiver
//   has no way to hold them, so it must take every word as it comes.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready only
//   while the block is idle and start is low.
// Sequence:
//   build: busy through setup, one rank-memory write per block (nb = product
//   of the four sizes, paced by the single write port) and the done word; the
//   done word is out in the first cycle in which busy is low.
//   query: busy through setup, coordinate reduction (one subtract per cycle until
//   every coordinate is in range), then nine rank-memory reads. The first result
//   is registered after the own-rank read and the read of face 0, then one
//   word per cycle; the last one is out in the first cycle in which busy is low.
// Reset: sizes go to 4, cut mask and first parity to 0, counters to 0; the rank
//   table holds nothing until the first build, and queries before it give zeros in all but direction and last.
`default_nettype none

module lattice_block_neighbour_indexer #(
    parameter int MAX_BLOCKS_PER_DIM = lbni_pkg::MAX_BLOCKS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire lbni_pkg::in_word_t              request,
    output lbni_pkg::out_word_t                  result,
    output logic                                 result_valid,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lbni_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lbni_pkg::CFG_DATA_W-1:0] cfg_data
);

    lbni_pkg::cmd_t    cmd;
    lbni_pkg::status_t status;

    assign cfg_ready = !busy && !start;

    lbni_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd)
    );

    lbni_dp #(
        .MAX_BLOCKS_PER_DIM (MAX_BLOCKS_PER_DIM)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .request      (request),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

// File: bench/tb_lattice_block_neighbour_indexer.sv
// Self-checking bench for the lattice block neighbour indexer: random and directed words.
`timescale 1ns / 1ps

module tb_lattice_block_neighbour_indexer;

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int SETTLE_CYCLES  = 40;

    class neighbour_scoreboard;
        bit [4:0]                  dims [4];
        bit [3:0]                  cut_mask;
        bit                        par_first;
        bit [lbni_pkg::RANK_W-1:0] ranks [65536];
        bit [lbni_pkg::CNT_W-1:0]  face_count [16];
        bit                        built;
        lbni_pkg::out_word_t       pending [$];
        int                        errors;
        int                        n_builds;
        int                        n_queries;
        int                        n_words;
        int                        n_boundary;

        function new();
            for (int i = 0; i < 4; i++)
                dims[i] = 5'd4;
            cut_mask = '0;
            par_first = 1'b0;
            built = 1'b0;
            for (int i = 0; i < 16; i++)
                face_count[i] = '0;
        endfunction

        function void write_reg(logic [lbni_pkg::CFG_IDX_W-1:0] idx,
                                logic [lbni_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                lbni_pkg::REG_BLOCKS_DIM0:   dims[0] = val;
                lbni_pkg::REG_BLOCKS_DIM1:   dims[1] = val;
                lbni_pkg::REG_BLOCKS_DIM2:   dims[2] = val;
                lbni_pkg::REG_BLOCKS_DIM3:   dims[3] = val;
                lbni_pkg::REG_CUT_FACE_MASK: cut_mask = val[3:0];
                lbni_pkg::REG_FIRST_PARITY:  par_first = val[0];
                default: ;
            endcase
        endfunction

        function int eff(int mu);
            int v;
            v = int'(dims[mu]);
            if (v < 1)
                v = 1;
            if (v > 16)
                v = 16;
            return v;
        endfunction

        function int lex(int c0, int c1, int c2, int c3);
            return ((c0 * eff(1) + c1) * eff(2) + c2) * eff(3) + c3;
        endfunction

        function void note(lbni_pkg::in_word_t w);
            int d [4];
            int c [4];
            int nc [4];
            int ne [8];
            int no [8];
            int oe [8];
            int oo [8];
            int nb, nbh, own, prod, nbb, m, ci, r0, r1;
            bit plus, at_edge, first_grp;
            lbni_pkg::out_word_t e;

            for (int mu = 0; mu < 4; mu++)
                d[mu] = eff(mu);
            nb = d[0] * d[1] * d[2] * d[3];
            nbh = nb / 2;

            if (w.operation == lbni_pkg::OP_BUILD) begin
                r0 = 0;
                r1 = nbh;
                for (int a = 0; a < d[0]; a++)
                    for (int b = 0; b < d[1]; b++)
                        for (int g = 0; g < d[2]; g++)
                            for (int h = 0; h < d[3]; h++) begin
                                if (((a + b + g + h) & 1) == int'(par_first)) begin
                                    ranks[lex(a, b, g, h)] = lbni_pkg::RANK_W'(r0);
                                    r0 = r0 + 1;
                                end
                                else begin
                                    ranks[lex(a, b, g, h)] = lbni_pkg::RANK_W'(r1);
                                    r1 = r1 + 1;
                                end
                            end
                for (int i = 0; i < 16; i++)
                    face_count[i] = '0;
                built = 1'b1;
                n_builds++;
                e = '0;
                e.build_done = 1'b1;
                e.last = 1'b1;
                pending.push_back(e);
                return;
            end

            n_queries++;
            if (!built) begin
                for (int f = 0; f < lbni_pkg::FACES; f++) begin
                    e = '0;
                    e.direction = lbni_pkg::FACE_W'(f);
                    e.last = (f == lbni_pkg::FACES - 1);
                    pending.push_back(e);
                end
                return;
            end

            c[0] = int'(w.coord0) % d[0];
            c[1] = int'(w.coord1) % d[1];
            c[2] = int'(w.coord2) % d[2];
            c[3] = int'(w.coord3) % d[3];
            own = int'(ranks[lex(c[0], c[1], c[2], c[3])]);

            // boundary slot counts per face and parity group
            for (int mu = 0; mu < 4; mu++) begin
                prod = 1;
                for (int nu = 0; nu < 4; nu++)
                    if (nu != mu)
                        prod *= d[nu];
                nbb = cut_mask[mu] ? prod : 0;
                if (par_first) begin
                    ne[2*mu] = (nbb + 1) / 2;
                    no[2*mu] = nbb - ne[2*mu];
                end
                else begin
                    no[2*mu] = (nbb + 1) / 2;
                    ne[2*mu] = nbb - no[2*mu];
                end
                if (d[mu] & 1) begin
                    ne[2*mu+1] = ne[2*mu];
                    no[2*mu+1] = no[2*mu];
                end
                else begin
                    ne[2*mu+1] = no[2*mu];
                    no[2*mu+1] = ne[2*mu];
                end
            end
            oe[0] = 0;
            for (int f = 1; f < 8; f++)
                oe[f] = oe[f-1] + ne[f-1];
            oo[0] = oe[7] + ne[7];
            for (int f = 1; f < 8; f++)
                oo[f] = oo[f-1] + no[f-1];

            for (int f = 0; f < lbni_pkg::FACES; f++) begin
                m = f >> 1;
                plus = ((f & 1) != 0);
                at_edge = plus ? (c[m] == d[m] - 1) : (c[m] == 0);
                nc = c;
                e = '0;
                e.block_index = lbni_pkg::RANK_W'(own);
                e.direction = lbni_pkg::FACE_W'(f);
                e.last = (f == lbni_pkg::FACES - 1);
                if (cut_mask[m] && at_edge) begin
                    first_grp = own < nbh;
                    ci = (first_grp ? 0 : 8) + f;
                    e.neighbour_index = lbni_pkg::NIDX_W'(nb + (first_grp ? oo[f] : oe[f]) +
                                                          int'(face_count[ci]));
                    face_count[ci] = face_count[ci] + lbni_pkg::CNT_W'(1);
                    nc[m] = plus ? 0 : d[m] - 1;
                    e.on_boundary = 1'b1;
                    e.far_partner_index = ranks[lex(nc[0], nc[1], nc[2], nc[3])];
                    n_boundary++;
                end
                else begin
                    nc[m] = plus ? (c[m] + 1) % d[m] : (c[m] + d[m] - 1) % d[m];
                    e.neighbour_index =
                        lbni_pkg::NIDX_W'(ranks[lex(nc[0], nc[1], nc[2], nc[3])]);
                end
                pending.push_back(e);
            end
        endfunction

        function void check(lbni_pkg::out_word_t r);
            lbni_pkg::out_word_t e;
            n_words++;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", r);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.block_index !== e.block_index) begin
                $error("block_index exp %0d act %0d", e.block_index, r.block_index);
                errors++;
            end
            if (r.direction !== e.direction) begin
                $error("direction exp %0d act %0d", e.direction, r.direction);
                errors++;
            end
            if (r.neighbour_index !== e.neighbour_index) begin
                $error("neighbour_index exp %0d act %0d", e.neighbour_index,
                       r.neighbour_index);
                errors++;
            end
            if (r.on_boundary !== e.on_boundary) begin
                $error("on_boundary exp %0d act %0d", e.on_boundary, r.on_boundary);
                errors++;
            end
            if (r.far_partner_index !== e.far_partner_index) begin
                $error("far_partner_index exp %0d act %0d", e.far_partner_index,
                       r.far_partner_index);
                errors++;
            end
            if (r.build_done !== e.build_done) begin
                $error("build_done exp %0d act %0d", e.build_done, r.build_done);
                errors++;
            end
            if (r.last !== e.last) begin
                $error("last exp %0d act %0d", e.last, r.last);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    lbni_pkg::in_word_t              request;
    lbni_pkg::out_word_t             result;
    logic                            result_valid;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lbni_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lbni_pkg::CFG_DATA_W-1:0] cfg_data;

    neighbour_scoreboard sb;
    int  items_sent;
    int  idle_cycles;
    int  sweep_pos;
    bit  no_gaps;

    lattice_block_neighbour_indexer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .result      (result),
        .result_valid(result_valid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check(result);
    end

    // counts cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if (!rst_n || result_valid || (start && !busy) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic pause(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send(lbni_pkg::in_word_t w);
        start <= 1'b1;
        request <= w;
        do
            @(posedge clk);
        while (busy);
        sb.note(w);
        items_sent++;
        pause(pick_gap());
    endtask

    task automatic send_query(int c0, int c1, int c2, int c3);
        lbni_pkg::in_word_t w;
        w.operation = lbni_pkg::OP_QUERY;
        w.coord0 = lbni_pkg::COORD_W'(c0);
        w.coord1 = lbni_pkg::COORD_W'(c1);
        w.coord2 = lbni_pkg::COORD_W'(c2);
        w.coord3 = lbni_pkg::COORD_W'(c3);
        send(w);
    endtask

    task automatic send_build();
        lbni_pkg::in_word_t w;
        w = '0;
        w.operation = lbni_pkg::OP_BUILD;
        w.coord0 = lbni_pkg::COORD_W'($urandom);
        w.coord1 = lbni_pkg::COORD_W'($urandom);
        w.coord2 = lbni_pkg::COORD_W'($urandom);
        w.coord3 = lbni_pkg::COORD_W'($urandom);
        send(w);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [lbni_pkg::CFG_IDX_W-1:0] idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= lbni_pkg::CFG_DATA_W'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, lbni_pkg::CFG_DATA_W'(val));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // next block in lexicographic sweep order, or a random word now and then
    task automatic sweep_query();
        int d1, d2, d3, nb, p;
        d1 = sb.eff(1);
        d2 = sb.eff(2);
        d3 = sb.eff(3);
        nb = sb.eff(0) * d1 * d2 * d3;
        if ($urandom_range(0, 9) < 2) begin
            send_query($urandom_range(0, 15), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 15));
        end
        else begin
            p = sweep_pos % nb;
            sweep_pos = p + 1;
            send_query(p / (d1 * d2 * d3), (p / (d2 * d3)) % d1, (p / d3) % d2, p % d3);
        end
    endtask

    task automatic run_phase(int d0, int d1, int d2, int d3, int mask, int par,
                             int nq, bit hold_mid);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(lbni_pkg::REG_BLOCKS_DIM0, d0);
        write_reg(lbni_pkg::REG_BLOCKS_DIM1, d1);
        write_reg(lbni_pkg::REG_BLOCKS_DIM2, d2);
        write_reg(lbni_pkg::REG_BLOCKS_DIM3, d3);
        write_reg(lbni_pkg::REG_CUT_FACE_MASK, mask);
        write_reg(lbni_pkg::REG_FIRST_PARITY, par);
        no_gaps = ($urandom_range(0, 3) == 0);
        send_build();
        sweep_pos = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095)) : 0;
        for (int i = 0; i < nq; i++) begin
            if (hold_mid && i == nq / 2)
                drain();
            // occasional rebuild mid-phase restarts the boundary counters
            if ($urandom_range(0, 49) == 0)
                send_build();
            sweep_query();
        end
    endtask

    function int rand_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r == 1)
            return $urandom_range(17, 31);
        return $urandom_range(1, 6);
    endfunction

    initial
    begin
        sb = new();
        items_sent = 0;
        sweep_pos = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // queries with no table yet give words that carry only direction and last
        send_query(0, 0, 0, 0);
        send_query(15, 15, 15, 15);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        // unused register slots, must be ignored
        write_reg(3'd6, 31);
        write_reg(3'd7, 0);

        // reset sizes, no cut faces, coords at extremes and out of range
        run_phase(4, 4, 4, 4, 0, 0, 0, 1'b0);
        send_query(0, 0, 0, 0);
        send_query(15, 15, 15, 15);
        send_query(3, 0, 3, 0);
        send_query(0, 3, 0, 3);
        send_query(5, 9, 2, 12);
        send_query(10, 5, 10, 5);
        // all faces cut, tiny lattice, every block hits several boundaries
        run_phase(2, 3, 2, 2, 15, 1, 14, 1'b0);
        // clamped sizes: 0 -> 1 and 31 -> 16
        run_phase(0, 1, 31, 1, 15, 0, 10, 1'b0);
        // odd block count
        run_phase(3, 5, 1, 3, 5, 1, 40, 1'b1);
        // largest lattice, kept short
        run_phase(16, 16, 16, 16, 15, 0, 12, 1'b0);
        run_phase(5, 2, 7, 3, 10, 1, 40, 1'b0);
        run_phase(1, 1, 1, 1, 15, 1, 10, 1'b0);

        while (items_sent < 380)
            run_phase(rand_dim(), rand_dim(), rand_dim(), rand_dim(),
                      $urandom_range(0, 15), $urandom_range(0, 1),
                      $urandom_range(10, 40), $urandom_range(0, 3) == 0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d words: %0d builds, %0d queries, %0d result words",
                 items_sent, sb.n_builds, sb.n_queries, sb.n_words);
        $display("%0d boundary faces seen, %0d field mismatches", sb.n_boundary, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
